FILE: rtl/matrix4_cofactor_inverse_core_macros.svh
// Assertion macros shared by the checker of the 4x4 matrix inverse core.
// Depends on nothing; included by the assertion checker.
`ifndef MATRIX4_COFACTOR_INVERSE_CORE_MACROS_SVH
`define MATRIX4_COFACTOR_INVERSE_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define MCI_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, disabled during reset
`define MCI_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: rtl/mci_pkg.sv
// Shared constants, types and helpers of the 4x4 matrix inverse core.
// Depends on nothing; used by all RTL files but the macro header.
package mci_pkg;

    localparam int ELEMENT_BITS_DEF  = 32;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int DIGIT_BITS        = 32;
    localparam int NDIG_BITS         = 3;

    typedef struct packed {
        logic                 acc_sel;
        logic                 load;
        logic                 negate;
        logic [NDIG_BITS-1:0] ndig;
    } t_mac_cmd;

    function automatic logic [1:0] skip_index(input logic [1:0] n, input logic [1:0] x);
        return (n < x) ? n : n + 2'd1;
    endfunction

    function automatic logic [3:0] elem_addr(input logic [1:0] col, input logic [1:0] row);
        return {col, row};
    endfunction

endpackage

FILE: rtl/mci_if.sv
// Valid/ready stream interfaces for matrix elements in and inverse elements out.
// Depends on mci_pkg.
interface mci_in_if #(parameter int ELEMENT_BITS = mci_pkg::ELEMENT_BITS_DEF) ();
    logic                           valid;
    logic                           ready;
    logic signed [ELEMENT_BITS-1:0] element_value;
    logic                           last_element;

    modport source (output valid, element_value, last_element, input ready);
    modport sink   (input valid, element_value, last_element, output ready);
endinterface

interface mci_out_if #(parameter int ELEMENT_BITS = mci_pkg::ELEMENT_BITS_DEF) ();
    logic                           valid;
    logic                           ready;
    logic signed [ELEMENT_BITS-1:0] result_value;
    logic [3:0]                     result_index;
    logic signed [ELEMENT_BITS-1:0] determinant;
    logic                           singular;
    logic                           last_result;

    modport source (output valid, result_value, result_index, determinant, singular,
                    last_result, input ready);
    modport sink   (input valid, result_value, result_index, determinant, singular,
                    last_result, output ready);
endinterface

FILE: rtl/mci_mac.sv
// Digit-serial multiply-accumulate unit with two wide accumulators.
// Depends on mci_pkg.
module mci_mac #(
    parameter int ELEMENT_BITS = mci_pkg::ELEMENT_BITS_DEF,
    parameter int ACC_BITS     = 4 * mci_pkg::ELEMENT_BITS_DEF + 5,
    parameter int NDIG         = 4
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  mci_pkg::t_mac_cmd                    i_cmd,
    input  logic [ELEMENT_BITS-1:0]              i_a,
    input  logic [NDIG*mci_pkg::DIGIT_BITS-1:0]  i_b,
    output logic                                 o_busy,
    output logic [ACC_BITS-1:0]                  o_acc0,
    output logic [ACC_BITS-1:0]                  o_acc1
);
    import mci_pkg::*;

    localparam int BW   = NDIG * DIGIT_BITS;
    localparam int PW   = ELEMENT_BITS + DIGIT_BITS + 1;
    localparam int CNTW = (NDIG > 1) ? $clog2(NDIG) : 1;

    logic                         r_run;
    logic                         r_pv;
    logic [CNTW-1:0]              r_cnt;
    logic [CNTW-1:0]              r_pcnt;
    t_mac_cmd                     r_cmd;
    logic [ELEMENT_BITS-1:0]      r_a;
    logic [BW-1:0]                r_b;
    logic signed [PW-1:0]         r_prod;
    logic [ACC_BITS-1:0]          r_acc0;
    logic [ACC_BITS-1:0]          r_acc1;

    logic [DIGIT_BITS-1:0]        dig [NDIG];
    logic                         last_dig;
    logic signed [DIGIT_BITS:0]   dig_ext;
    logic signed [PW-1:0]         prod;
    logic signed [ACC_BITS-1:0]   term;
    logic [ACC_BITS-1:0]          base;
    logic [ACC_BITS-1:0]          acc_next;

    always_comb begin
        for (int d = 0; d < NDIG; d++) begin
            dig[d] = r_b[d*DIGIT_BITS +: DIGIT_BITS];
        end
    end

    assign last_dig = (NDIG_BITS'(r_cnt) == (r_cmd.ndig - NDIG_BITS'(1)));
    assign dig_ext  = last_dig ? {dig[r_cnt][DIGIT_BITS-1], dig[r_cnt]}
                               : {1'b0, dig[r_cnt]};
    assign prod     = PW'(signed'(r_a) * dig_ext);

    always_comb begin
        term = ACC_BITS'(r_prod) << (r_pcnt * DIGIT_BITS);
        if (r_cmd.load && (r_pcnt == '0)) begin
            base = '0;
        end else begin
            base = r_cmd.acc_sel ? r_acc1 : r_acc0;
        end
        acc_next = r_cmd.negate ? (base - term) : (base + term);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_pv  <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_pv <= r_run;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + CNTW'(1);
                if (last_dig) begin
                    r_run <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_cmd <= i_cmd;
        end
        if (r_run) begin
            r_prod <= prod;
            r_pcnt <= r_cnt;
        end
        if (r_pv) begin
            if (r_cmd.acc_sel) begin
                r_acc1 <= acc_next;
            end else begin
                r_acc0 <= acc_next;
            end
        end
    end

    assign o_busy = r_run | r_pv;
    assign o_acc0 = r_acc0;
    assign o_acc1 = r_acc1;

endmodule

FILE: rtl/mci_div.sv
// Restoring divider: cofactor scaled by 2^(2F) over the determinant, rounded and saturated.
// Depends on mci_pkg.
module mci_div #(
    parameter int ELEMENT_BITS  = mci_pkg::ELEMENT_BITS_DEF,
    parameter int FRACTION_BITS = mci_pkg::FRACTION_BITS_DEF,
    parameter int COF_BITS      = 3 * mci_pkg::ELEMENT_BITS_DEF + 3,
    parameter int DET_BITS      = 4 * mci_pkg::ELEMENT_BITS_DEF + 5
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [COF_BITS-1:0]     i_num,
    input  logic [DET_BITS-1:0]     i_den_mag,
    input  logic                    i_den_neg,
    output logic                    o_busy,
    output logic [ELEMENT_BITS-1:0] o_quot
);
    import mci_pkg::*;

    localparam int QB   = ELEMENT_BITS + 1;
    localparam int NW   = COF_BITS + 2 * FRACTION_BITS;
    localparam int HW   = NW - QB;
    localparam int CMPW = (HW > DET_BITS) ? HW : DET_BITS;
    localparam int RW   = DET_BITS + 1;
    localparam int QW   = ELEMENT_BITS + 2;
    localparam int CW   = $clog2(QB);

    localparam logic [2:0] DV_IDLE  = 3'd0;
    localparam logic [2:0] DV_ABS   = 3'd1;
    localparam logic [2:0] DV_SETUP = 3'd2;
    localparam logic [2:0] DV_ITER  = 3'd3;
    localparam logic [2:0] DV_RND   = 3'd4;
    localparam logic [2:0] DV_FIN   = 3'd5;

    localparam logic [QW-1:0] LIM = QW'(1) << (ELEMENT_BITS - 1);

    logic [2:0]              r_st;
    logic [CW-1:0]           r_cnt;
    logic [COF_BITS-1:0]     r_num;
    logic [COF_BITS-1:0]     r_nmag;
    logic                    r_qneg;
    logic [DET_BITS-1:0]     r_d;
    logic [RW-1:0]           r_rem;
    logic [QB-1:0]           r_lo;
    logic [QB-1:0]           r_q;
    logic                    r_ovf;
    logic                    r_rup;
    logic [ELEMENT_BITS-1:0] r_quot;

    logic [NW-1:0]           nsh;
    logic [HW-1:0]           hi;
    logic [RW-1:0]           trial;
    logic [RW:0]             diff;
    logic [QW-1:0]           mag;
    logic [QW-1:0]           mcl;

    assign nsh   = {r_nmag, {(2*FRACTION_BITS){1'b0}}};
    assign hi    = nsh[NW-1:QB];
    assign trial = {r_rem[RW-2:0], r_lo[QB-1]};
    assign diff  = {1'b0, trial} - {2'b00, r_d};

    always_comb begin
        mag = QW'(r_q) + QW'(r_rup);
        if (r_ovf) begin
            mcl = r_qneg ? LIM : LIM - QW'(1);
        end else if (r_qneg) begin
            mcl = (mag > LIM) ? LIM : mag;
        end else begin
            mcl = (mag > LIM - QW'(1)) ? LIM - QW'(1) : mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= DV_IDLE;
        end else begin
            unique case (r_st)
                DV_IDLE:  if (i_start) r_st <= DV_ABS;
                DV_ABS:   r_st <= DV_SETUP;
                DV_SETUP: r_st <= DV_ITER;
                DV_ITER:  if (r_cnt == CW'(QB - 1)) r_st <= DV_RND;
                DV_RND:   r_st <= DV_FIN;
                DV_FIN:   r_st <= DV_IDLE;
                default:  r_st <= DV_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            DV_IDLE: begin
                if (i_start) begin
                    r_num  <= i_num;
                    r_qneg <= i_num[COF_BITS-1] ^ i_den_neg;
                    r_d    <= i_den_mag;
                end
            end
            DV_ABS: begin
                r_nmag <= r_num[COF_BITS-1] ? (~r_num + COF_BITS'(1)) : r_num;
            end
            DV_SETUP: begin
                r_ovf <= (CMPW'(hi) >= CMPW'(r_d));
                r_rem <= RW'(hi);
                r_lo  <= nsh[QB-1:0];
                r_q   <= '0;
                r_cnt <= '0;
            end
            DV_ITER: begin
                if (!diff[RW]) begin
                    r_rem <= diff[RW-1:0];
                end else begin
                    r_rem <= trial;
                end
                r_q   <= {r_q[QB-2:0], ~diff[RW]};
                r_lo  <= r_lo << 1;
                r_cnt <= r_cnt + CW'(1);
            end
            DV_RND: begin
                r_rup <= ({r_rem, 1'b0} >= {2'b00, r_d});
            end
            DV_FIN: begin
                r_quot <= r_qneg ? ELEMENT_BITS'(~mcl + QW'(1)) : ELEMENT_BITS'(mcl);
            end
            default: ;
        endcase
    end

    assign o_busy = (r_st != DV_IDLE);
    assign o_quot = r_quot;

endmodule

FILE: rtl/matrix4_cofactor_inverse_core.sv
// 4x4 matrix inverse by cofactors (adjugate over determinant), exact fixed point.
// Channel i_in takes sixteen elements in column-major order, the last one flagged
// by last_element. Each accepted transaction is written to the matrix memory;
// no result is produced until the flagged element arrives.
// Channel o_out then delivers sixteen transactions in column-major order, each
// with the inverse element, its index, the determinant and the singular flag.
// A singular matrix is echoed unchanged with a zero determinant.
// After the last element a sequencer runs all products through one digit-serial
// multiply-accumulate unit (32-bit digits), for each cofactor and then for the
// determinant, then one restoring divider produces each result one quotient bit per cycle.
// i_in is ready only while loading; the next matrix may load while the final
// result still waits in the output register. A stalled o_out holds the sequencer
// before the next result, never losing one. Reset returns to loading at index 0;
// the memories are not cleared.
module matrix4_cofactor_inverse_core #(
    parameter int ELEMENT_BITS  = mci_pkg::ELEMENT_BITS_DEF,
    parameter int FRACTION_BITS = mci_pkg::FRACTION_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    mci_in_if.sink           i_in,
    mci_out_if.source        o_out
);
    import mci_pkg::*;

    localparam int E    = ELEMENT_BITS;
    localparam int F    = FRACTION_BITS;
    localparam int M2W  = 2 * E + 1;
    localparam int CW   = 3 * E + 3;
    localparam int DW   = 4 * E + 5;
    localparam int NDIG = (CW + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int BW   = NDIG * DIGIT_BITS;
    localparam logic [NDIG_BITS-1:0] ND_E = NDIG_BITS'((E + DIGIT_BITS - 1) / DIGIT_BITS);
    localparam logic [NDIG_BITS-1:0] ND_M = NDIG_BITS'((M2W + DIGIT_BITS - 1) / DIGIT_BITS);
    localparam logic [NDIG_BITS-1:0] ND_C = NDIG_BITS'(NDIG);

    localparam logic [3:0] ST_LOAD   = 4'd0;
    localparam logic [3:0] ST_RA     = 4'd1;
    localparam logic [3:0] ST_RB     = 4'd2;
    localparam logic [3:0] ST_GO     = 4'd3;
    localparam logic [3:0] ST_WAIT   = 4'd4;
    localparam logic [3:0] ST_WCOF   = 4'd5;
    localparam logic [3:0] ST_DABS   = 4'd6;
    localparam logic [3:0] ST_DRND   = 4'd7;
    localparam logic [3:0] ST_ERD    = 4'd8;
    localparam logic [3:0] ST_DSTART = 4'd9;
    localparam logic [3:0] ST_DWAIT  = 4'd10;
    localparam logic [3:0] ST_EMIT   = 4'd11;

    localparam logic [1:0] U_FIRST  = 2'd0;
    localparam logic [1:0] U_SECOND = 2'd1;
    localparam logic [1:0] U_TERM   = 2'd2;

    localparam logic [DW:0] DET_HALF = (DW + 1)'(1) << (3 * F - 1);
    localparam logic [DW:0] DET_LIM  = (DW + 1)'(1) << (E - 1);

    logic [E-1:0]  r_mat [16];
    logic [E-1:0]  r_mat_q;
    logic [CW-1:0] r_cof [16];
    logic [CW-1:0] r_cof_q;

    logic [3:0]    r_state;
    logic [3:0]    r_pos;
    logic [3:0]    r_k;
    logic [1:0]    r_t;
    logic [1:0]    r_u;
    logic          r_det;
    logic [E-1:0]  r_opa;
    logic          r_sing;
    logic          r_dneg;
    logic [DW-1:0] r_dmag;
    logic [E-1:0]  r_det_out;

    logic          r_ov;
    logic [E-1:0]  r_res_value;
    logic [3:0]    r_res_index;
    logic [E-1:0]  r_res_det;
    logic          r_res_sing;
    logic          r_res_last;

    logic          in_acc;
    logic          out_free;
    logic [1:0]    ci, rj, sp, sq;
    logic [1:0]    col_p, col_q, col_t, row0, row1, row2;
    logic [3:0]    addr_a, addr_b, mat_raddr, cof_raddr;
    t_mac_cmd      mac_cmd;
    logic [BW-1:0] mac_b;
    logic          mac_busy;
    logic [DW-1:0] mac_acc0, mac_acc1;
    logic          div_busy;
    logic [E-1:0]  div_quot;
    logic [DW:0]   det_sum, det_magr, det_mcl;
    logic [E-1:0]  det_round;

    assign in_acc   = i_in.valid && (r_state == ST_LOAD);
    assign out_free = !r_ov || o_out.ready;

    always_comb begin
        ci    = r_k[1:0];
        rj    = r_k[3:2];
        sp    = (r_t == 2'd0) ? 2'd1 : 2'd0;
        sq    = (r_t == 2'd2) ? 2'd1 : 2'd2;
        col_p = skip_index(sp, ci);
        col_q = skip_index(sq, ci);
        col_t = skip_index(r_t, ci);
        row0  = skip_index(2'd0, rj);
        row1  = skip_index(2'd1, rj);
        row2  = skip_index(2'd2, rj);
        if (r_det) begin
            addr_a = elem_addr(2'd0, r_k[1:0]);
        end else begin
            unique case (r_u)
                U_FIRST:  addr_a = elem_addr(col_p, row1);
                U_SECOND: addr_a = elem_addr(col_q, row1);
                default:  addr_a = elem_addr(col_t, row0);
            endcase
        end
        addr_b = (r_u == U_FIRST) ? elem_addr(col_q, row2) : elem_addr(col_p, row2);
        if ((r_state == ST_ERD) || (r_state == ST_EMIT)) begin
            mat_raddr = r_k;
        end else if (r_state == ST_RB) begin
            mat_raddr = addr_b;
        end else begin
            mat_raddr = addr_a;
        end
        cof_raddr = (r_det && (r_state == ST_RB)) ? {r_k[1:0], 2'b00} : r_k;
    end

    always_comb begin
        if (r_det) begin
            mac_cmd = '{acc_sel: 1'b1, load: (r_k == 4'd0), negate: 1'b0, ndig: ND_C};
            mac_b   = BW'(signed'(r_cof_q));
        end else begin
            unique case (r_u)
                U_FIRST: begin
                    mac_cmd = '{acc_sel: 1'b0, load: 1'b1, negate: 1'b0, ndig: ND_E};
                    mac_b   = BW'(signed'(r_mat_q));
                end
                U_SECOND: begin
                    mac_cmd = '{acc_sel: 1'b0, load: 1'b0, negate: 1'b1, ndig: ND_E};
                    mac_b   = BW'(signed'(r_mat_q));
                end
                default: begin
                    mac_cmd = '{acc_sel: 1'b1, load: (r_t == 2'd0),
                                negate: (r_t == 2'd1) ^ ci[0] ^ rj[0], ndig: ND_M};
                    mac_b   = BW'(signed'(mac_acc0[M2W-1:0]));
                end
            endcase
        end
    end

    always_comb begin
        det_sum  = {1'b0, r_dmag} + DET_HALF;
        det_magr = det_sum >> (3 * F);
        if (r_dneg) begin
            det_mcl   = (det_magr > DET_LIM) ? DET_LIM : det_magr;
            det_round = E'(~det_mcl + (DW + 1)'(1));
        end else begin
            det_mcl   = (det_magr > DET_LIM - (DW + 1)'(1)) ? DET_LIM - (DW + 1)'(1) : det_magr;
            det_round = E'(det_mcl);
        end
    end

    mci_mac #(
        .ELEMENT_BITS (E),
        .ACC_BITS     (DW),
        .NDIG         (NDIG)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_GO),
        .i_cmd   (mac_cmd),
        .i_a     (r_opa),
        .i_b     (mac_b),
        .o_busy  (mac_busy),
        .o_acc0  (mac_acc0),
        .o_acc1  (mac_acc1)
    );

    mci_div #(
        .ELEMENT_BITS  (E),
        .FRACTION_BITS (F),
        .COF_BITS      (CW),
        .DET_BITS      (DW)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_state == ST_DSTART),
        .i_num     (r_cof_q),
        .i_den_mag (r_dmag),
        .i_den_neg (r_dneg),
        .o_busy    (div_busy),
        .o_quot    (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mat[r_pos] <= i_in.element_value;
        end
        r_mat_q <= r_mat[mat_raddr];
        if (r_state == ST_WCOF) begin
            r_cof[r_k] <= mac_acc1[CW-1:0];
        end
        r_cof_q <= r_cof[cof_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_pos   <= '0;
            r_k     <= '0;
            r_t     <= '0;
            r_u     <= U_FIRST;
            r_det   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if ((r_state == ST_EMIT) && out_free) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                ST_LOAD: begin
                    if (in_acc) begin
                        r_pos <= i_in.last_element ? 4'd0 : r_pos + 4'd1;
                        if (i_in.last_element) begin
                            r_k     <= '0;
                            r_t     <= '0;
                            r_u     <= U_FIRST;
                            r_det   <= 1'b0;
                            r_state <= ST_RA;
                        end
                    end
                end
                ST_RA: r_state <= ST_RB;
                ST_RB: r_state <= ST_GO;
                ST_GO: r_state <= ST_WAIT;
                ST_WAIT: begin
                    if (!mac_busy) begin
                        if (r_det) begin
                            if (r_k == 4'd3) begin
                                r_state <= ST_DABS;
                            end else begin
                                r_k     <= r_k + 4'd1;
                                r_state <= ST_RA;
                            end
                        end else if (r_u != U_TERM) begin
                            r_u     <= r_u + 2'd1;
                            r_state <= ST_RA;
                        end else begin
                            r_u <= U_FIRST;
                            if (r_t != 2'd2) begin
                                r_t     <= r_t + 2'd1;
                                r_state <= ST_RA;
                            end else begin
                                r_t     <= '0;
                                r_state <= ST_WCOF;
                            end
                        end
                    end
                end
                ST_WCOF: begin
                    if (r_k == 4'd15) begin
                        r_det <= 1'b1;
                    end
                    r_k     <= r_k + 4'd1;
                    r_state <= ST_RA;
                end
                ST_DABS: r_state <= ST_DRND;
                ST_DRND: begin
                    r_k     <= '0;
                    r_state <= ST_ERD;
                end
                ST_ERD: r_state <= r_sing ? ST_EMIT : ST_DSTART;
                ST_DSTART: r_state <= ST_DWAIT;
                ST_DWAIT: begin
                    if (!div_busy) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_k <= r_k + 4'd1;
                        if (r_k == 4'd15) begin
                            r_state <= ST_LOAD;
                        end else begin
                            r_state <= ST_ERD;
                        end
                    end
                end
                default: r_state <= ST_LOAD;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_RB) begin
            r_opa <= r_mat_q;
        end
        if (r_state == ST_DABS) begin
            r_sing <= (mac_acc1 == '0);
            r_dneg <= mac_acc1[DW-1];
            r_dmag <= mac_acc1[DW-1] ? (~mac_acc1 + DW'(1)) : mac_acc1;
        end
        if (r_state == ST_DRND) begin
            r_det_out <= r_sing ? '0 : det_round;
        end
        if ((r_state == ST_EMIT) && out_free) begin
            r_res_value <= r_sing ? r_mat_q : div_quot;
            r_res_index <= r_k;
            r_res_det   <= r_det_out;
            r_res_sing  <= r_sing;
            r_res_last  <= (r_k == 4'd15);
        end
    end

    assign i_in.ready         = (r_state == ST_LOAD);
    assign o_out.valid        = r_ov;
    assign o_out.result_value = r_res_value;
    assign o_out.result_index = r_res_index;
    assign o_out.determinant  = r_res_det;
    assign o_out.singular     = r_res_sing;
    assign o_out.last_result  = r_res_last;

endmodule

FILE: rtl/mci_checker.sv
// Port-level checks of the 4x4 matrix inverse core, bound to its top level.
// Depends on matrix4_cofactor_inverse_core_macros.svh and mci_pkg.
`include "matrix4_cofactor_inverse_core_macros.svh"

module mci_checker #(
    parameter int ELEMENT_BITS = mci_pkg::ELEMENT_BITS_DEF
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_ready,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic [ELEMENT_BITS-1:0] i_out_value,
    input logic [3:0]              i_out_index,
    input logic [ELEMENT_BITS-1:0] i_out_det,
    input logic                    i_out_sing,
    input logic                    i_out_last
);
    `MCI_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_out_value) && $stable(i_out_index))
    `MCI_ASSERT_IMPLY(a_last_index, i_clk, i_rst_n, i_out_valid,
        i_out_last == (i_out_index == 4'd15))
    `MCI_ASSERT_IMPLY(a_sing_det, i_clk, i_rst_n, i_out_valid && i_out_sing, i_out_det == '0)
    `MCI_ASSERT_IMPLY(a_no_load_midway, i_clk, i_rst_n, i_out_valid && !i_out_last,
        !i_in_ready)
endmodule

bind matrix4_cofactor_inverse_core mci_checker #(
    .ELEMENT_BITS (ELEMENT_BITS)
) u_mci_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_value (o_out.result_value),
    .i_out_index (o_out.result_index),
    .i_out_det   (o_out.determinant),
    .i_out_sing  (o_out.singular),
    .i_out_last  (o_out.last_result)
);

FILE: bench/tb_matrix4_cofactor_inverse_core.sv
// Self-checking bench for the 4x4 cofactor matrix inverse core.
// Depends on mci_pkg, the mci_in_if/mci_out_if interfaces and the core itself.
module tb_matrix4_cofactor_inverse_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int EB = mci_pkg::ELEMENT_BITS_DEF;
    localparam int FB = mci_pkg::FRACTION_BITS_DEF;
    localparam int IDLE_LIMIT = 20000;

    typedef logic signed [255:0] wide_t;
    typedef logic signed [EB-1:0] elem_t;

    typedef struct {
        elem_t      value;
        logic [3:0] index;
        elem_t      det;
        logic       sing;
        logic       last;
    } inv_result_t;

    class inverse_scoreboard;
        elem_t       store[16];
        int          pos;
        inv_result_t inv_q[$];
        int          errors;
        int          matrices;
        int          singulars;
        int          results;

        function new();
            pos = 0;
            errors = 0;
            matrices = 0;
            singulars = 0;
            results = 0;
        endfunction

        function wide_t round_div(wide_t n, wide_t d);
            wide_t an, ad, q, r;
            an = (n < 0) ? -n : n;
            ad = (d < 0) ? -d : d;
            q = an / ad;
            r = an - q * ad;
            if (2 * r >= ad) q = q + 1;
            return ((n < 0) != (d < 0)) ? -q : q;
        endfunction

        function elem_t clamp(wide_t v);
            wide_t hi, lo;
            hi = (wide_t'(1) <<< (EB - 1)) - 1;
            lo = -(wide_t'(1) <<< (EB - 1));
            if (v > hi) return elem_t'(hi);
            if (v < lo) return elem_t'(lo);
            return elem_t'(v);
        endfunction

        function wide_t minor_det(int drow, int dcol);
            int    rr[3], cc[3], n, i;
            wide_t a[3][3];
            n = 0;
            for (i = 0; i < 4; i++) if (i != drow) begin rr[n] = i; n++; end
            n = 0;
            for (i = 0; i < 4; i++) if (i != dcol) begin cc[n] = i; n++; end
            for (i = 0; i < 9; i++) a[i / 3][i % 3] = wide_t'(store[cc[i % 3] * 4 + rr[i / 3]]);
            return a[0][0] * (a[1][1] * a[2][2] - a[1][2] * a[2][1])
                 - a[0][1] * (a[1][0] * a[2][2] - a[1][2] * a[2][0])
                 + a[0][2] * (a[1][0] * a[2][1] - a[1][1] * a[2][0]);
        endfunction

        function void note_element(elem_t v, logic last);
            wide_t       adj[16], det;
            inv_result_t r;
            int          k;
            store[pos] = v;
            pos = (pos + 1) % 16;
            if (!last) return;
            pos = 0;
            matrices++;
            for (k = 0; k < 16; k++) begin
                adj[k] = minor_det(k >> 2, k & 3);
                if (((k & 3) + (k >> 2)) % 2 == 1) adj[k] = -adj[k];
            end
            det = 0;
            for (k = 0; k < 4; k++) det = det + wide_t'(store[k]) * adj[k * 4];
            if (det == 0) singulars++;
            for (k = 0; k < 16; k++) begin
                r.index = 4'(k);
                r.last  = (k == 15);
                r.sing  = (det == 0);
                if (det == 0) begin
                    r.value = store[k];
                    r.det   = 0;
                end else begin
                    r.value = clamp(round_div(adj[k] <<< (2 * FB), det));
                    r.det   = clamp(round_div(det, wide_t'(1) <<< (3 * FB)));
                end
                inv_q.push_back(r);
            end
        endfunction

        function void check_result(inv_result_t got);
            inv_result_t e;
            results++;
            if (inv_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result index %0d value %h",
                                           got.index, got.value);
                return;
            end
            e = inv_q.pop_front();
            if (got.value !== e.value || got.index !== e.index || got.det !== e.det ||
                got.sing !== e.sing || got.last !== e.last) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp idx %0d val %h det %h sing %b last %b | got idx %0d val %h det %h sing %b last %b",
                             e.index, e.value, e.det, e.sing, e.last,
                             got.index, got.value, got.det, got.sing, got.last);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    mci_in_if  in_if ();
    mci_out_if out_if ();

    matrix4_cofactor_inverse_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #10 i_clk = ~i_clk;

    inverse_scoreboard sb = new();
    int send_idle = 0;
    int recv_idle = 0;
    int idle_cycles = 0;
    inv_result_t got;

    initial begin
        in_if.valid = 1'b0;
        in_if.element_value = '0;
        in_if.last_element = 1'b0;
        out_if.ready = 1'b0;
    end

    always @(negedge i_clk) out_if.ready <= ($urandom_range(99) >= recv_idle);

    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready)
            sb.note_element(in_if.element_value, in_if.last_element);
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got.value = out_if.result_value;
            got.index = out_if.result_index;
            got.det   = out_if.determinant;
            got.sing  = out_if.singular;
            got.last  = out_if.last_result;
            sb.check_result(got);
        end
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_elem(elem_t v, logic last);
        while ($urandom_range(99) < send_idle) begin
            in_if.valid = 1'b0;
            @(negedge i_clk);
        end
        in_if.valid = 1'b1;
        in_if.element_value = v;
        in_if.last_element = last;
        do @(posedge i_clk); while (!in_if.ready);
        @(negedge i_clk);
    endtask

    function automatic elem_t rand_elem(int kind);
        case (kind)
            0: return elem_t'($urandom);
            1: return elem_t'($signed($urandom_range(8 << FB)) - (4 << FB));
            default: return elem_t'(($signed($urandom_range(16)) - 8) <<< FB);
        endcase
    endfunction

    task automatic send_matrix(int kind, bit make_singular, int extra);
        elem_t m[16];
        int    k;
        for (k = 0; k < 16; k++) m[k] = rand_elem(kind);
        if (make_singular) for (k = 12; k < 16; k++) m[k] = m[k - 12];
        for (k = 0; k < extra; k++) send_elem(rand_elem(0), 1'b0);
        for (k = 0; k < 16; k++) send_elem(m[k], k == 15);
    endtask

    initial begin
        int k, n;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // identity, then early last on a full store with extreme elements
        send_idle = 16;
        recv_idle = 63;
        for (k = 0; k < 16; k++) send_elem((k % 5 == 0) ? elem_t'(1 << FB) : '0, k == 15);
        send_elem({1'b0, {(EB - 1){1'b1}}}, 1'b1);
        send_elem({1'b1, {(EB - 1){1'b0}}}, 1'b0);
        send_elem({1'b1, {(EB - 1){1'b0}}}, 1'b1);
        for (n = 0; n < 12; n++) begin
            if (n == 4) begin send_idle = 63; recv_idle = 16; end
            if (n == 8) begin send_idle = 0; recv_idle = 0; end
            case ($urandom_range(9))
                0: send_matrix($urandom_range(2), 1'b1, 0);
                1: send_matrix($urandom_range(2), 1'b0, $urandom_range(1, 6));
                2: begin
                    for (k = $urandom_range(1, 14); k > 0; k--) send_elem(rand_elem(1), 1'b0);
                    send_elem(rand_elem(1), 1'b1);
                end
                default: send_matrix($urandom_range(2), 1'b0, 0);
            endcase
        end
        in_if.valid = 1'b0;
        while (sb.inv_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("covered %0d matrices (%0d singular), %0d results checked, %0d mismatches",
                 sb.matrices, sb.singulars, sb.results, sb.errors);
        if (sb.errors == 0 && sb.inv_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
